// ===== rtl/hbk_pkg.sv =====
// Shared types, constants and the usage-code to ASCII mapping of the
// boot keyboard translator. No dependencies.
package hbk_pkg;

	localparam int KEY_SLOTS  = 6;  // stored and compared key slots
	localparam int KEY_FIELDS = 6;  // key code fields in one report beat
	localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
	localparam logic [7:0] SHIFT_MASK     = 8'h22;

	typedef logic [7:0] code_t;
	typedef logic [6:0] char_t;
	typedef code_t [KEY_SLOTS-1:0]  slot_codes_t;
	typedef code_t [KEY_FIELDS-1:0] field_codes_t;

	typedef struct packed {
		logic  hit;  // new key with an ASCII mapping
		char_t ch;
	} lane_res_t;

	typedef lane_res_t [KEY_SLOTS-1:0] lane_res_arr_t;

	localparam code_t CODE_LETTER_LO = 8'h04;
	localparam code_t CODE_LETTER_HI = 8'h1D;
	localparam code_t CODE_DIGIT_LO  = 8'h1E;
	localparam code_t CODE_DIGIT_HI  = 8'h27;
	localparam code_t CODE_ENTER     = 8'h28;
	localparam code_t CODE_BKSP      = 8'h2A;
	localparam code_t CODE_TAB       = 8'h2B;
	localparam code_t CODE_SPACE     = 8'h2C;
	localparam code_t CODE_PUNCT_LO  = 8'h2D;
	localparam code_t CODE_PUNCT_HI  = 8'h38;

	localparam char_t CH_LOWER_A = 7'h61;
	localparam char_t CH_UPPER_A = 7'h41;
	localparam char_t CH_LF      = 7'h0A;
	localparam char_t CH_BS      = 7'h08;
	localparam char_t CH_HT      = 7'h09;
	localparam char_t CH_SPACE   = 7'h20;
	localparam char_t CH_NONE    = 7'h00;

	// 1..9 0 and their shifted forms
	localparam char_t DIGIT_PLAIN [10] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
	};
	localparam char_t DIGIT_SHIFT [10] = '{
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
	};
	// - = [ ] \ (none) ; ' ` , . /   and shifted forms
	localparam char_t PUNCT_PLAIN [12] = '{
		7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00,
		7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
	};
	localparam char_t PUNCT_SHIFT [12] = '{
		7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00,
		7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
	};

	// US layout; returns CH_NONE for unmapped codes
	function automatic char_t to_ascii(input code_t code, input logic shifted);
		char_t      res;
		logic [3:0] idx_d;
		logic [3:0] idx_p;
		code_t      off;
		idx_d = 4'(code - CODE_DIGIT_LO);
		idx_p = 4'(code - CODE_PUNCT_LO);
		off   = code - CODE_LETTER_LO;
		case (code) inside
			[CODE_LETTER_LO:CODE_LETTER_HI]:
				res = (shifted ? CH_UPPER_A : CH_LOWER_A) + off[6:0];
			[CODE_DIGIT_LO:CODE_DIGIT_HI]:
				res = shifted ? DIGIT_SHIFT[idx_d] : DIGIT_PLAIN[idx_d];
			CODE_ENTER: res = CH_LF;
			CODE_BKSP:  res = CH_BS;
			CODE_TAB:   res = CH_HT;
			CODE_SPACE: res = CH_SPACE;
			[CODE_PUNCT_LO:CODE_PUNCT_HI]:
				res = shifted ? PUNCT_SHIFT[idx_p] : PUNCT_PLAIN[idx_p];
			default:    res = CH_NONE;
		endcase
		return res;
	endfunction

endpackage

// ===== rtl/hbk_if.sv =====
// Valid/ready channel interfaces for report beats and character beats.
// No dependencies.
interface hbk_report_if;
	logic                valid;
	logic                ready;
	logic [7:0]          modifiers;
	logic [7:0]          key_code_0;
	logic [7:0]          key_code_1;
	logic [7:0]          key_code_2;
	logic [7:0]          key_code_3;
	logic [7:0]          key_code_4;
	logic [7:0]          key_code_5;
	logic [6:0]          report_length;

	modport source (
		output valid, modifiers, key_code_0, key_code_1, key_code_2,
		       key_code_3, key_code_4, key_code_5, report_length,
		input  ready
	);
	modport sink (
		input  valid, modifiers, key_code_0, key_code_1, key_code_2,
		       key_code_3, key_code_4, key_code_5, report_length,
		output ready
	);
endinterface

interface hbk_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;
	logic       last_of_report;

	modport source (output valid, ascii_char, last_of_report, input ready);
	modport sink   (input valid, ascii_char, last_of_report, output ready);
endinterface

// ===== rtl/hbk_lane.sv =====
// One key slot: new-press detection against the previous report and mapping.
// Depends on hbk_pkg.
module hbk_lane (
	input  hbk_pkg::code_t       code,
	input  logic                 shifted,
	input  hbk_pkg::slot_codes_t prev_keys,
	output hbk_pkg::lane_res_t   res
);
	import hbk_pkg::*;

	logic  held;
	char_t ch;

	always_comb begin
		held = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (prev_keys[j] == code)
				held = 1'b1;
		end
	end

	assign ch     = to_ascii(code, shifted);
	assign res.ch  = ch;
	assign res.hit = (code != '0) && !held && (ch != CH_NONE);

endmodule

// ===== rtl/hbk_merge.sv =====
// Collects the lane results of one report and serializes the hits in slot
// order, one character beat per cycle while the sink is ready. Depends on hbk_pkg and hbk_if.
module hbk_merge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,     // accepted long report
	input  hbk_pkg::lane_res_arr_t lanes,
	output logic                   ready,
	hbk_char_if.source             out_ch
);
	import hbk_pkg::*;

	logic                 valid_s1;
	logic [KEY_SLOTS-1:0] mask_s1;
	char_t                ch_s1 [KEY_SLOTS];

	logic [KEY_SLOTS-1:0] mask_q;
	char_t                ch_q [KEY_SLOTS];

	logic [KEY_SLOTS-1:0] low_bit;
	logic [KEY_SLOTS-1:0] rest;
	logic                 drain_free;
	logic                 advance;
	logic                 out_fire;
	char_t                sel_ch;

	assign low_bit    = mask_q & (~mask_q + KEY_SLOTS'(1));
	assign rest       = mask_q & ~low_bit;
	assign out_fire   = out_ch.valid && out_ch.ready;
	assign drain_free = (mask_q == '0) || (out_fire && rest == '0);
	assign advance    = valid_s1 && drain_free;
	assign ready      = !valid_s1 || drain_free;

	always_comb begin
		sel_ch = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (low_bit[i])
				sel_ch = sel_ch | ch_q[i];
		end
	end

	assign out_ch.valid          = (mask_q != '0);
	assign out_ch.ascii_char     = sel_ch;
	assign out_ch.last_of_report = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				mask_s1[i] <= lanes[i].hit;
				ch_s1[i]   <= lanes[i].ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (advance) begin
			mask_q <= mask_s1;
		end else if (out_fire) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			ch_q <= ch_s1;
	end

endmodule

// ===== rtl/hid_boot_keyboard_to_ascii_unit.sv =====
// Top level of the boot keyboard report to ASCII translator.
// Depends on hbk_pkg, hbk_if, hbk_lane and hbk_merge.
//
//   channel   dir  payload                                      beats
//   report    in   modifiers, key_code_0..5, report_length      one per report
//   key_char  out  ascii_char, last_of_report                   0..6 per report
//
// A report is taken whole: six lanes compare their slot against the
// stored previous keys and map it, and the hits are registered. The merge
// stage then sends one character per cycle while key_char is ready. The
// next report is accepted while characters of the previous one are still
// leaving. Reset clears the previous keys and drops all pending characters.
// Reports shorter than 8 bytes are accepted and discarded. A stall on
// key_char backs up into report after one buffered report.
module hid_boot_keyboard_to_ascii_unit (
	input  logic         clk,
	input  logic         arst_n,
	hbk_report_if.sink   report,
	hbk_char_if.source   key_char
);
	import hbk_pkg::*;

	slot_codes_t   prev_q;
	slot_codes_t   cur;
	field_codes_t  fields;
	lane_res_arr_t lane_res;
	logic          shifted;
	logic          long_rpt;
	logic          accept;
	logic          merge_ready;

	assign fields = {report.key_code_5, report.key_code_4, report.key_code_3,
	                 report.key_code_2, report.key_code_1, report.key_code_0};

	// slots beyond the report's key fields read as empty
	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
		if (i < KEY_FIELDS) begin : g_fld
			assign cur[i] = fields[i];
		end else begin : g_zero
			assign cur[i] = '0;
		end
	end

	assign shifted      = (report.modifiers & SHIFT_MASK) != '0;
	assign long_rpt     = report.report_length >= MIN_REPORT_LEN;
	assign report.ready = merge_ready;
	assign accept       = report.valid && report.ready && long_rpt;

	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
		hbk_lane u_lane (
			.code      (cur[i]),
			.shifted   (shifted),
			.prev_keys (prev_q),
			.res       (lane_res[i])
		);
	end

	// previous keys follow every long report, hits or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= cur;
		end
	end

	hbk_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.lanes  (lane_res),
		.ready  (merge_ready),
		.out_ch (key_char)
	);

endmodule
